/* design/tmlf_pkg.sv */
`default_nettype none

package tmlf_pkg;

    // Sample and byte widths fixed by the converter format.
    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;

    // Default window depth and the ceiling value after reset.
    localparam int                  WINDOW_DEPTH_DEFAULT = 6;
    localparam logic [SAMPLE_W-1:0] CEILING_RESET        = 16'd65528;

    // One accepted input item after unpacking.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } tmlf_item_t;

endpackage

`default_nettype wire

/* design/tmlf_window.sv */
`default_nettype none

module tmlf_window
    import tmlf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
)
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    load,
    input  wire tmlf_item_t                              item,
    output logic       [WINDOW_DEPTH-1:0][SAMPLE_W-1:0]  window_next
);

    localparam int POS_W = $clog2(WINDOW_DEPTH);

    logic [WINDOW_DEPTH-1:0][SAMPLE_W-1:0] window_reg;
    logic [POS_W-1:0]                      pos_reg;
    logic [POS_W-1:0]                      pos_next;
    logic                                  primed_reg;
    logic                                  refill;

    // A restart, or the first sample after reset, floods every slot.
    assign refill = item.restart || !primed_reg;

    always_comb
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (refill || (pos_reg == POS_W'(i)))
            begin
                window_next[i] = item.sample;
            end
            else
            begin
                window_next[i] = window_reg[i];
            end
        end
        pos_next = (pos_reg == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_reg + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else if (load)
        begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
            primed_reg <= 1'b1;
        end
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(WINDOW_DEPTH - 1))
        else $error("write position left the window");

    a_primed_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> primed_reg)
        else $error("window not primed after a sample");

endmodule

`default_nettype wire

/* design/tmlf_reduce.sv */
`default_nettype none

module tmlf_reduce
    import tmlf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
)
(
    input  wire logic [WINDOW_DEPTH-1:0][SAMPLE_W-1:0] window,
    input  wire logic [SAMPLE_W-1:0]                   ceiling,
    output logic      [SAMPLE_W-1:0]                   level
);

    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int DIVISOR = WINDOW_DEPTH - 2;
    // Reciprocal with enough fraction bits that the truncated product is
    // the exact quotient for every possible trimmed sum.
    localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
    localparam int MUL_W   = SHIFT + 1;
    localparam int PROD_W  = SUM_W + MUL_W;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

    logic [SUM_W-1:0]    total;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
    logic [SUM_W-1:0]    trimmed;
    logic [PROD_W-1:0]   product;
    logic [SAMPLE_W-1:0] quotient;

    always_comb
    begin
        total = '0;
        hi    = window[0];
        lo    = window[0];
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            total = total + SUM_W'(window[i]);
            if (window[i] > hi)
            begin
                hi = window[i];
            end
            if (window[i] < lo)
            begin
                lo = window[i];
            end
        end
        trimmed  = total - SUM_W'(hi) - SUM_W'(lo);
        product  = PROD_W'(trimmed) * PROD_W'(MUL_W'(RECIP));
        quotient = product[SHIFT +: SAMPLE_W];
        level    = (quotient > ceiling) ? ceiling : quotient;
    end

endmodule

`default_nettype wire

/* design/trimmed_mean_light_filter.sv */
// Channel  Direction  Payload                                       Transaction when
// s_*      in         tdata: sample_low [7:0], sample_high [15:8]   s_tvalid && s_tready
//                     tuser: restart [0]
// m_*      out        tdata: filtered_level [15:0]                  m_tvalid && m_tready
// cfg_*    in         data: output_ceiling [15:0]                   cfg_valid && cfg_ready
//
// An accepted sample waits in the input register while the window update and trimmed-mean
// logic run, and the result register loads at the next edge on which it is empty or being
// drained: m_tvalid rises as it loads, and the output transaction comes at a later edge.
// One sample per clock is sustained while the output side keeps up.
// Reset clears the window, the write position, the primed flag and both valid flags, and loads
// the ceiling default. A stalled output holds its result and back-pressure reaches s_tready.

`default_nettype none

module trimmed_mean_light_filter
    import tmlf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Input stream.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [15:0]         s_tdata,   // sample_low [7:0], sample_high [15:8]
    input  wire logic [0:0]          s_tuser,   // restart [0]
    // Result stream.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [15:0]         m_tdata,   // filtered_level [15:0]
    // Ceiling register write channel.
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [SAMPLE_W-1:0] cfg_data
);

    tmlf_item_t                            item_reg;
    logic                                  in_valid_reg;
    logic [SAMPLE_W-1:0]                   out_data_reg;
    logic [SAMPLE_W-1:0]                   out_data_next;
    logic                                  out_valid_reg;
    logic [SAMPLE_W-1:0]                   ceiling_reg;
    logic                                  advance;
    logic                                  fire;
    logic [WINDOW_DEPTH-1:0][SAMPLE_W-1:0] window_next;

    // The result register can take a new value when it is empty or is being
    // drained this cycle; the input register moves on under the same terms.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.sample  <= {s_tdata[2*BYTE_W-1:BYTE_W], s_tdata[BYTE_W-1:0]};
            item_reg.restart <= s_tuser[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg <= CEILING_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ceiling_reg <= cfg_data;
        end
    end

    // Window storage: updated once per sample, and its post-update contents
    // feed the reduction in the same cycle.
    tmlf_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .item        (item_reg),
        .window_next (window_next)
    );

    tmlf_reduce #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_reduce (
        .window  (window_next),
        .ceiling (ceiling_reg),
        .level   (out_data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed sample produced no result");

    a_result_under_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && $past(fire)) |-> (out_data_reg <= $past(ceiling_reg)))
        else $error("result above ceiling");

    a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("empty input register refused a sample");

endmodule

`default_nettype wire

/* bench/trimmed_mean_light_filter_tb.sv */
`default_nettype none

module trimmed_mean_light_filter_tb;
    import tmlf_pkg::*;

    // The window depth used by the instance below; the predictor follows it.
    localparam int DEPTH = WINDOW_DEPTH_DEFAULT;

    // Number of random samples sent in each ceiling phase.
    localparam int PHASE_SAMPLES = 150;

    // Cycles allowed after the last result for anything still in flight.
    localparam int SETTLE_CYCLES = 6;

    // The run is stopped here if it has not finished by then.
    localparam int RUN_LIMIT = 5_000_000;

    // Predicts the filtered level of every accepted sample and checks the
    // results of the block against those predictions in order.
    class level_scoreboard;
        logic [SAMPLE_W-1:0] window [DEPTH];
        int unsigned         write_slot;
        bit                  primed;
        logic [SAMPLE_W-1:0] ceiling;
        logic [SAMPLE_W-1:0] expected_levels [$];
        int unsigned         mismatch_count;

        function new();
            foreach (window[i])
                window[i] = '0;
            write_slot     = 0;
            primed         = 1'b0;
            ceiling        = CEILING_RESET;
            mismatch_count = 0;
        endfunction

        function void load_ceiling(logic [SAMPLE_W-1:0] value);
            ceiling = value;
        endfunction

        // Updates the window with one accepted sample and queues the level
        // that the block has to report for it.
        function void note_sample(logic [SAMPLE_W-1:0] sample, logic restart);
            int unsigned total;
            int unsigned hi;
            int unsigned lo;
            int unsigned level;
            int unsigned v;
            if (restart || !primed)
            begin
                foreach (window[i])
                    window[i] = sample;
                primed = 1'b1;
            end
            else
            begin
                window[write_slot] = sample;
            end
            write_slot = (write_slot + 1 >= DEPTH) ? 0 : write_slot + 1;

            total = 0;
            hi    = 32'(window[0]);
            lo    = 32'(window[0]);
            foreach (window[i])
            begin
                v = 32'(window[i]);
                total += v;
                if (v > hi)
                    hi = v;
                if (v < lo)
                    lo = v;
            end
            level = (total - hi - lo) / (DEPTH - 2);
            if (level > 32'(ceiling))
                level = 32'(ceiling);
            expected_levels.push_back(level[SAMPLE_W-1:0]);
        endfunction

        function void check_level(logic [SAMPLE_W-1:0] actual);
            logic [SAMPLE_W-1:0] wanted;
            if (expected_levels.size() == 0)
            begin
                $display("%0t: result with nothing expected, filtered_level actual %h",
                         $time, actual);
                mismatch_count++;
                return;
            end
            wanted = expected_levels.pop_front();
            if (actual !== wanted)
            begin
                $display("%0t: filtered_level mismatch, expected %h actual %h",
                         $time, wanted, actual);
                mismatch_count++;
            end
        endfunction

        function int outstanding();
            return expected_levels.size();
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;    // sample_low [7:0], sample_high [15:8]
    logic [0:0]          s_tuser   = '0;    // restart [0]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;           // filtered_level [15:0]
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SAMPLE_W-1:0] cfg_data  = '0;

    // Switches for the random idling of each side; both are changed per phase
    // so that some stretches run with no gaps at all.
    bit source_gaps_on = 1'b0;
    bit sink_stalls_on = 1'b0;
    int sink_hold      = 0;

    level_scoreboard sb;

    trimmed_mean_light_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Gap lengths: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Samples lean toward the extremes and toward the current ceiling so that
    // clamping and the trimming of the largest and smallest entry both happen
    // often, while plain random values cover every bit.
    function automatic logic [15:0] pick_sample();
        logic [31:0] bits;
        bits = $urandom;
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return sb.ceiling + 16'(bits[2:0]) - 16'd4;
            3:       return {8'h00, bits[7:0]};
            4:       return {bits[7:0], 8'h00};
            default: return bits[15:0];
        endcase
    endfunction

    // All three channels are observed at the rising edge. Input and result
    // transactions of the same edge never belong to the same sample, since a
    // result only leaves the block after passing the input and result registers.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.load_ceiling(cfg_data);
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready)
                sb.check_level(m_tdata);
        end
    end

    // The result side stalls at random whenever stalls are switched on.
    always @(negedge clk)
    begin
        if (sink_hold != 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (sink_stalls_on)
                sink_hold <= pick_gap();
        end
    end

    // Sends one sample. It is entered and left just after a falling edge, so
    // tvalid stays high from one transaction to the next when no gap is taken.
    task automatic send_sample(logic [15:0] sample, logic restart);
        int gap;
        s_tvalid   <= 1'b1;
        s_tdata    <= sample;
        s_tuser[0] <= restart;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        gap = source_gaps_on ? pick_gap() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Holds the input back until every expected result has come out, then
    // lets the pipeline settle before anything else is done.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes the ceiling; only called while the block is idle.
    task automatic write_ceiling(logic [SAMPLE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random samples with an occasional restart; the first half of the
    // second phase ends with a full drain of the results.
    task automatic send_random(int count, bit drain_midway);
        for (int n = 0; n < count; n++)
        begin
            if (drain_midway && n == count / 2)
                drain_results();
            send_sample(pick_sample(), ($urandom_range(0, 19) == 0));
        end
    endtask

    initial
    begin
        logic [SAMPLE_W-1:0] phase_ceilings [6];
        logic [16:0]         directed_items [$];

        sb = new();

        // Ceilings for the random phases, the two extremes among them.
        phase_ceilings[0] = 16'hFFFF;
        phase_ceilings[1] = 16'h0000;
        phase_ceilings[2] = 16'h8000;
        phase_ceilings[3] = 16'($urandom);
        phase_ceilings[4] = 16'h00FF;
        phase_ceilings[5] = 16'h7FFF;

        // Directed samples as {restart, sample}. The first one fills the
        // window because nothing has been written since reset, and its level
        // is clamped to the ceiling that reset loads. The plain writes that
        // follow go all the way around the ring, and a restart in the middle
        // and near the end refills the whole window.
        directed_items = '{
            {1'b0, 16'hFFFF},
            {1'b0, 16'h0000}, {1'b0, 16'h00FF}, {1'b0, 16'hFF00},
            {1'b0, 16'hFFFF}, {1'b0, 16'h0001}, {1'b0, 16'h8000},
            {1'b0, 16'h7FFF}, {1'b0, 16'hFFF8},
            {1'b1, 16'h1234},
            {1'b0, 16'hFFFF}, {1'b0, 16'hFFFF}, {1'b0, 16'hFFFF},
            {1'b0, 16'hFFFF}, {1'b0, 16'hFFFF}, {1'b0, 16'hFFFF},
            {1'b0, 16'h0000},
            {1'b1, 16'hFFFF},
            {1'b1, 16'h0000}, {1'b0, 16'hFFFE}, {1'b0, 16'h0003},
            {1'b0, 16'hFFF9}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset ceiling, back to back on both sides.
        foreach (directed_items[k])
            send_sample(directed_items[k][15:0], directed_items[k][16]);

        // Random phases, each with its own ceiling and idling pattern.
        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            write_ceiling(phase_ceilings[p]);
            source_gaps_on = (p % 4 == 0) || (p % 4 == 1);
            sink_stalls_on = (p % 4 == 0) || (p % 4 == 2);
            send_random(PHASE_SAMPLES, (p == 1));
        end

        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        drain_results();

        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
